/* src/ggc_pkg.sv */
// Shared constants and types of the greedy graph coloring block.
package ggc_pkg;

   localparam int MAX_NODES   = 4096;
   localparam int MAX_COLORS  = 32;
   localparam int NODE_W      = $clog2(MAX_NODES);
   localparam int ROW_W       = NODE_W + 1;
   localparam int COLOR_W     = $clog2(MAX_COLORS + 1);
   localparam int MASK_IDX_W  = $clog2(MAX_COLORS);
   localparam int COUNT_W     = NODE_W + 1;
   localparam int TALLY_DEPTH = MAX_COLORS + 1;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

   localparam int CSR_IDX_W   = 1;
   localparam int CSR_DATA_W  = 13;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_NUM_ROWS    = 1'b0,
      CSR_COLOR_LIMIT = 1'b1
   } csr_index_type;

   // One operation handed from the front to the back.
   typedef struct packed {
      logic              restart;
      logic [NODE_W-1:0] row;
      logic [NODE_W-1:0] nb;
      logic              nb_ok;
      logic              last;
      logic              done;
   } ggc_op_type;

endpackage

/* src/ggc_front.sv */
// Front end: accepts transactions, tracks the row number and classifies entries.
module ggc_front (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic                      req_cmd,
   input  logic [ggc_pkg::NODE_W-1:0] req_neighbor,
   input  logic                      req_has_entry,
   input  logic                      req_last_of_row,
   input  logic [ggc_pkg::ROW_W-1:0] rows_eff,
   input  logic                      q_full,
   output logic                      push,
   output ggc_pkg::ggc_op_type       push_op
);
   import ggc_pkg::*;

   logic [ROW_W-1:0] row_ff, row_in;
   logic             accept;
   logic             in_graph;

   assign req_ready = !q_full;
   assign accept    = req_valid && !q_full;
   assign in_graph  = row_ff < rows_eff;

   always_comb begin
      push_op.restart = req_cmd;
      push_op.row     = row_ff[NODE_W-1:0];
      push_op.nb      = req_neighbor;
      // Only rows already colored in this graph hold a color; others read as uncolored.
      push_op.nb_ok   = req_has_entry && ({1'b0, req_neighbor} < row_ff);
      push_op.last    = req_last_of_row;
      push_op.done    = (row_ff + ROW_W'(1)) == rows_eff;
      push = accept && (req_cmd || (in_graph && (push_op.nb_ok || req_last_of_row)));
      row_in = row_ff;
      if (accept) begin
         if (req_cmd) begin
            row_in = '0;
         end else if (in_graph && req_last_of_row) begin
            row_in = row_ff + ROW_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff <= '0;
      end else begin
         row_ff <= row_in;
      end
   end

endmodule

/* src/ggc_queue.sv */
// Short queue of operations between the front end and the back end.
module ggc_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  ggc_pkg::ggc_op_type push_op,
   output logic                full,
   input  logic                pop,
   output logic                head_valid,
   output ggc_pkg::ggc_op_type head_op
);
   import ggc_pkg::*;

   ggc_op_type        slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [QPTR_W:0]   cnt_ff, cnt_in;
   logic              do_push, do_pop;

   assign full       = cnt_ff == (QPTR_W+1)'(QUEUE_DEPTH);
   assign head_valid = cnt_ff != '0;
   assign head_op    = slot_ff[rd_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_in  = do_push ? wr_ff + QPTR_W'(1) : wr_ff;
      rd_in  = do_pop  ? rd_ff + QPTR_W'(1) : rd_ff;
      cnt_in = cnt_ff;
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + (QPTR_W+1)'(1);
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - (QPTR_W+1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ff] <= push_op;
      end
   end

endmodule

/* src/ggc_back.sv */
// Back end: color lookup, forbidden mask and first-fit pick, per-color tally, result register.
module ggc_back (
   input  logic                        clock,
   input  logic                        reset,
   input  logic [ggc_pkg::COLOR_W-1:0] limit,
   input  logic                        head_valid,
   input  ggc_pkg::ggc_op_type         head_op,
   output logic                        pop,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [ggc_pkg::NODE_W-1:0]  rsp_row_index,
   output logic [ggc_pkg::COLOR_W-1:0] rsp_assigned_color,
   output logic                        rsp_overflow,
   output logic [ggc_pkg::COUNT_W-1:0] rsp_rows_in_color,
   output logic [ggc_pkg::COLOR_W-1:0] rsp_colors_used,
   output logic                        rsp_graph_done
);
   import ggc_pkg::*;

   logic adv;

   // Stage one: node color read and first-fit pick.
   logic [COLOR_W-1:0]    node_mem [MAX_NODES];
   logic [COLOR_W-1:0]    node_rd_ff;
   logic                  s1_valid_ff;
   ggc_op_type            s1_op_ff;
   logic                  nfwd_hit_ff;
   logic [COLOR_W-1:0]    nfwd_col_ff;
   logic [MAX_COLORS-1:0] mask_ff, mask_in;
   logic [COLOR_W-1:0]    nb_col;
   logic [MAX_COLORS-1:0] mask_all;
   logic [COLOR_W-1:0]    chosen;
   logic                  s1_end;
   logic                  node_we;

   // Stage two: tally update.
   logic [COUNT_W-1:0]     tally_mem [TALLY_DEPTH];
   logic [COUNT_W-1:0]     tally_rd_ff;
   logic [TALLY_DEPTH-1:0] tally_ok_ff, tally_ok_in;
   logic                   s2_valid_ff;
   logic                   s2_restart_ff;
   logic [NODE_W-1:0]      s2_row_ff;
   logic [COLOR_W-1:0]     s2_col_ff;
   logic                   s2_done_ff;
   logic                   tfwd_hit_ff;
   logic [COUNT_W-1:0]     tfwd_val_ff;
   logic [COUNT_W-1:0]     tally_old, tally_new;
   logic [COLOR_W-1:0]     high_ff, high_in, high_new;
   logic                   tally_we;

   // Result register.
   logic               out_valid_ff;
   logic [NODE_W-1:0]  out_row_ff;
   logic [COLOR_W-1:0] out_col_ff;
   logic [COUNT_W-1:0] out_cnt_ff;
   logic [COLOR_W-1:0] out_used_ff;
   logic               out_done_ff;

   assign adv = !out_valid_ff || rsp_ready;
   assign pop = adv && head_valid;

   always_comb begin
      nb_col   = nfwd_hit_ff ? nfwd_col_ff : node_rd_ff;
      mask_all = mask_ff;
      if (s1_op_ff.nb_ok && nb_col != '0) begin
         mask_all[MASK_IDX_W'(nb_col - COLOR_W'(1))] = 1'b1;
      end
      // Walk down so the smallest free color is the one that remains.
      chosen = '0;
      for (int k = MAX_COLORS; k >= 1; k--) begin
         if (COLOR_W'(k) <= limit && !mask_all[MASK_IDX_W'(k - 1)]) begin
            chosen = COLOR_W'(k);
         end
      end
      s1_end  = s1_valid_ff && !s1_op_ff.restart && s1_op_ff.last;
      node_we = adv && s1_end;
      mask_in = mask_ff;
      if (adv && s1_valid_ff) begin
         mask_in = (s1_op_ff.restart || s1_op_ff.last) ? '0 : mask_all;
      end
   end

   always_ff @(posedge clock) begin
      if (node_we) begin
         node_mem[s1_op_ff.row] <= chosen;
      end
      if (adv) begin
         node_rd_ff <= node_mem[head_op.nb];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         mask_ff     <= '0;
      end else begin
         if (adv) begin
            s1_valid_ff <= head_valid;
         end
         mask_ff <= mask_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_op_ff    <= head_op;
         nfwd_hit_ff <= node_we && (head_op.nb == s1_op_ff.row);
         nfwd_col_ff <= chosen;
      end
   end

   always_comb begin
      if (tfwd_hit_ff) begin
         tally_old = tfwd_val_ff;
      end else if (tally_ok_ff[s2_col_ff]) begin
         tally_old = tally_rd_ff;
      end else begin
         tally_old = '0;
      end
      tally_new   = tally_old + COUNT_W'(1);
      high_new    = (s2_col_ff > high_ff) ? s2_col_ff : high_ff;
      tally_we    = adv && s2_valid_ff && !s2_restart_ff;
      tally_ok_in = tally_ok_ff;
      high_in     = high_ff;
      if (adv && s2_valid_ff) begin
         if (s2_restart_ff) begin
            tally_ok_in = '0;
            high_in     = '0;
         end else begin
            tally_ok_in[s2_col_ff] = 1'b1;
            high_in                = high_new;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (tally_we) begin
         tally_mem[s2_col_ff] <= tally_new;
      end
      if (adv) begin
         tally_rd_ff <= tally_mem[chosen];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff  <= 1'b0;
         tally_ok_ff  <= '0;
         high_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         if (adv) begin
            s2_valid_ff  <= s1_valid_ff && (s1_op_ff.restart || s1_op_ff.last);
            out_valid_ff <= s2_valid_ff && !s2_restart_ff;
         end
         tally_ok_ff <= tally_ok_in;
         high_ff     <= high_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s2_restart_ff <= s1_op_ff.restart;
         s2_row_ff     <= s1_op_ff.row;
         s2_col_ff     <= chosen;
         s2_done_ff    <= s1_op_ff.done;
         tfwd_hit_ff   <= tally_we && (chosen == s2_col_ff);
         tfwd_val_ff   <= tally_new;
         out_row_ff    <= s2_row_ff;
         out_col_ff    <= s2_col_ff;
         out_cnt_ff    <= tally_new;
         out_used_ff   <= high_new;
         out_done_ff   <= s2_done_ff;
      end
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_row_index      = out_row_ff;
   assign rsp_assigned_color = out_col_ff;
   assign rsp_overflow       = out_col_ff == '0;
   assign rsp_rows_in_color  = out_cnt_ff;
   assign rsp_colors_used    = out_used_ff;
   assign rsp_graph_done     = out_done_ff;

endmodule

/* src/greedy_graph_coloring.sv */
// Top level of the first-fit greedy graph coloring block.
//
// Usage: each req_ transaction carries one column index of the current row, with
// req_last_of_row on the final one; req_cmd high starts a new graph and clears all
// colors, tallies and the row number. An empty row is sent as one transaction with
// req_has_entry low and req_last_of_row high. Each row end inside the graph gives
// one rsp_ transaction: the row, its color (0 with rsp_overflow high when nothing
// up to the limit was free), the running count of rows holding that color, the
// highest color so far and a flag on the graph's last row.
// The csr_ channel writes num_rows (index 0) and color_limit (index 1); it is
// always ready; the user must see that it is written only while the block is
// idle, which the block itself does not enforce. Throughput is one transaction
// per cycle while req_ready is high. A row-end transaction passes through the
// queue, the color lookup and first-fit stage and the tally stage into the output
// register. Colors are kept in a 4096-entry memory read once per cycle while the
// back end advances; a neighbor counts only if its row was already colored in
// this graph, so no clearing pass is needed after reset or restart. Reset returns
// the registers to 4096 rows and 32 colors. When rsp_ready is low the back end
// holds, the queue fills, and req_ready drops once its four entries are taken.
module greedy_graph_coloring (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic                           req_cmd,
   input  logic [ggc_pkg::NODE_W-1:0]     req_neighbor,
   input  logic                           req_has_entry,
   input  logic                           req_last_of_row,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [ggc_pkg::NODE_W-1:0]     rsp_row_index,
   output logic [ggc_pkg::COLOR_W-1:0]    rsp_assigned_color,
   output logic                           rsp_overflow,
   output logic [ggc_pkg::COUNT_W-1:0]    rsp_rows_in_color,
   output logic [ggc_pkg::COLOR_W-1:0]    rsp_colors_used,
   output logic                           rsp_graph_done,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [ggc_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [ggc_pkg::CSR_DATA_W-1:0] csr_data
);
   import ggc_pkg::*;

   logic [ROW_W-1:0]   num_rows_ff, num_rows_in;
   logic [COLOR_W-1:0] limit_ff, limit_in;
   logic [ROW_W-1:0]   rows_eff;
   logic [COLOR_W-1:0] limit_eff;

   logic       q_full;
   logic       push;
   ggc_op_type push_op;
   logic       pop;
   logic       head_valid;
   ggc_op_type head_op;

   assign csr_ready = 1'b1;

   // Register writes; both registers keep their value across a restart.
   always_comb begin
      num_rows_in = num_rows_ff;
      limit_in    = limit_ff;
      if (csr_valid) begin
         case (csr_index_type'(csr_index))
            CSR_NUM_ROWS:    num_rows_in = csr_data[ROW_W-1:0];
            CSR_COLOR_LIMIT: limit_in    = csr_data[COLOR_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         num_rows_ff <= ROW_W'(MAX_NODES);
         limit_ff    <= COLOR_W'(MAX_COLORS);
      end else begin
         num_rows_ff <= num_rows_in;
         limit_ff    <= limit_in;
      end
   end

   // The row count is capped by the color memory and the limit by the mask width.
   assign rows_eff  = (num_rows_ff > ROW_W'(MAX_NODES)) ? ROW_W'(MAX_NODES) : num_rows_ff;
   assign limit_eff = (limit_ff > COLOR_W'(MAX_COLORS)) ? COLOR_W'(MAX_COLORS) : limit_ff;

   ggc_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_cmd         (req_cmd),
      .req_neighbor    (req_neighbor),
      .req_has_entry   (req_has_entry),
      .req_last_of_row (req_last_of_row),
      .rows_eff        (rows_eff),
      .q_full          (q_full),
      .push            (push),
      .push_op         (push_op)
   );

   ggc_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_op    (push_op),
      .full       (q_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_op    (head_op)
   );

   ggc_back u_back (
      .clock              (clock),
      .reset              (reset),
      .limit              (limit_eff),
      .head_valid         (head_valid),
      .head_op            (head_op),
      .pop                (pop),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_row_index      (rsp_row_index),
      .rsp_assigned_color (rsp_assigned_color),
      .rsp_overflow       (rsp_overflow),
      .rsp_rows_in_color  (rsp_rows_in_color),
      .rsp_colors_used    (rsp_colors_used),
      .rsp_graph_done     (rsp_graph_done)
   );

endmodule
